[rtl/klk_pkg.sv]
package klk_pkg;

  localparam int MAX_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int PW_W       = 80;
  localparam int LOW_W      = 64;
  localparam int HIGH_W     = 16;
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 5;

  localparam logic [DIGIT_W-1:0] MAX_DIGIT_VALUE = 4'd9;

  typedef enum logic [1:0] {
    CMD_DIGIT = 2'd0,
    CMD_BACK  = 2'd1,
    CMD_ENTER = 2'd2,
    CMD_START = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_OPEN      = 3'd1,
    OUT_OLD_OK    = 3'd2,
    OUT_NEW_TAKEN = 3'd3,
    OUT_CHANGED   = 3'd4,
    OUT_ERROR     = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    PH_VERIFY  = 2'd0,
    PH_OLD     = 2'd1,
    PH_NEW     = 2'd2,
    PH_CONFIRM = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_PW_LOW  = 2'd0,
    REG_PW_HIGH = 2'd1,
    REG_PW_LEN  = 2'd2,
    REG_MODE    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [PW_W-1:0]    pw_digits;
    logic [COUNT_W-1:0] pw_length;
    logic               flow_mode;
  } cfg_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [COUNT_W-1:0] entry_length;
    phase_t             flow_state;
    logic [PW_W-1:0]    new_digits;
    logic [COUNT_W-1:0] new_length;
  } res_t;

endpackage

[rtl/klk_regs.sv]
module klk_regs
  import klk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [LOW_W-1:0]   pw_low;
  logic [HIGH_W-1:0]  pw_high;
  logic [COUNT_W-1:0] pw_length;
  logic               flow_mode;
  reg_index_t         reg_index;
  logic               wr_en;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[ADDR_W-1:3]);
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_low    <= '0;
      pw_high   <= '0;
      pw_length <= '0;
      flow_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_index)
        REG_PW_LOW:  pw_low    <= pwdata;
        REG_PW_HIGH: pw_high   <= pwdata[HIGH_W-1:0];
        REG_PW_LEN:  pw_length <= pwdata[COUNT_W-1:0];
        REG_MODE:    flow_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PW_LOW:  prdata = pw_low;
      REG_PW_HIGH: prdata = {{(DATA_W-HIGH_W){1'b0}}, pw_high};
      REG_PW_LEN:  prdata = {{(DATA_W-COUNT_W){1'b0}}, pw_length};
      REG_MODE:    prdata = {{(DATA_W-1){1'b0}}, flow_mode};
      default:     prdata = '0;
    endcase
  end

  assign cfg.pw_digits = {pw_high, pw_low};
  assign cfg.pw_length = pw_length;
  assign cfg.flow_mode = flow_mode;

endmodule

[rtl/klk_core.sv]
module klk_core
  import klk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  command_t           command,
  input  logic [DIGIT_W-1:0] digit,
  input  cfg_t               cfg,
  output res_t               res
);

  logic [DIGIT_W-1:0] entry_digits [MAX_DIGITS];
  logic [DIGIT_W-1:0] candidate_digits [MAX_DIGITS];
  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] entry_count_next;
  logic [COUNT_W-1:0] candidate_count;
  phase_t             flow_phase;
  phase_t             flow_phase_next;

  logic     digit_wr;
  logic     take_candidate;
  logic     match_stored;
  logic     match_candidate;
  outcome_t outcome;
  logic [PW_W-1:0] cand_word;

  // parallel digit compares
  always_comb begin
    match_stored    = (entry_count == cfg.pw_length);
    match_candidate = (entry_count == candidate_count);
    cand_word       = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (COUNT_W'(i) < entry_count) begin
        if (entry_digits[i] != cfg.pw_digits[DIGIT_W*i +: DIGIT_W]) match_stored = 1'b0;
        if (entry_digits[i] != candidate_digits[i]) match_candidate = 1'b0;
      end
      if (COUNT_W'(i) < candidate_count) begin
        cand_word[DIGIT_W*i +: DIGIT_W] = candidate_digits[i];
      end
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    flow_phase_next  = flow_phase;
    outcome          = OUT_NONE;
    digit_wr         = 1'b0;
    take_candidate   = 1'b0;
    case (command)
      CMD_DIGIT: begin
        if (digit <= MAX_DIGIT_VALUE && entry_count < COUNT_W'(MAX_DIGITS)) begin
          digit_wr         = 1'b1;
          entry_count_next = entry_count + 1'b1;
        end
      end
      CMD_BACK: begin
        if (entry_count != '0) entry_count_next = entry_count - 1'b1;
      end
      CMD_START: begin
        entry_count_next = '0;
        flow_phase_next  = cfg.flow_mode ? PH_OLD : PH_VERIFY;
      end
      CMD_ENTER: begin
        case (flow_phase)
          PH_VERIFY: begin
            if (match_stored) begin
              outcome          = OUT_OPEN;
              entry_count_next = '0;
            end else begin
              outcome = OUT_ERROR;
            end
          end
          PH_OLD: begin
            if (match_stored) begin
              outcome          = OUT_OLD_OK;
              entry_count_next = '0;
              flow_phase_next  = PH_NEW;
            end else begin
              outcome = OUT_ERROR;
            end
          end
          PH_NEW: begin
            outcome          = OUT_NEW_TAKEN;
            take_candidate   = 1'b1;
            entry_count_next = '0;
            flow_phase_next  = PH_CONFIRM;
          end
          PH_CONFIRM: begin
            if (match_candidate) begin
              outcome          = OUT_CHANGED;
              entry_count_next = '0;
              flow_phase_next  = PH_VERIFY;
            end else begin
              outcome = OUT_ERROR;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res.outcome      = outcome;
    res.entry_length = entry_count_next;
    res.flow_state   = flow_phase_next;
    res.new_digits   = (outcome == OUT_CHANGED) ? cand_word : '0;
    res.new_length   = (outcome == OUT_CHANGED) ? candidate_count : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      candidate_count <= '0;
      flow_phase      <= PH_VERIFY;
    end else if (go) begin
      entry_count <= entry_count_next;
      flow_phase  <= flow_phase_next;
      if (take_candidate) candidate_count <= entry_count;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (go && digit_wr && entry_count == COUNT_W'(i)) entry_digits[i] <= digit;
      if (go && take_candidate) candidate_digits[i] <= entry_digits[i];
    end
  end

endmodule

[rtl/keypad_password_lock_unit.sv]
// Keypad combination lock: takes one keypad transaction (digit, backspace, enter, start)
// per cycle unless stalled and returns one result transaction for each, through the input
// register, then the result register. The entry and candidate buffers are held in
// flip-flops and the full 20-digit compare against the stored or candidate password is
// combinational, which sets the rate of one transaction per clock while out_stall is low.
// The stored password and the flow chosen by start are set over the register port;
// flow_mode takes effect at the next start. There is no clearing pass after reset.
module keypad_password_lock_unit
  import klk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [DIGIT_W-1:0] digit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         outcome,
  output logic [COUNT_W-1:0] entry_length,
  output logic [1:0]         flow_state,
  output logic [LOW_W-1:0]   new_digits_low,
  output logic [HIGH_W-1:0]  new_digits_high,
  output logic [COUNT_W-1:0] new_length
);

  cfg_t               cfg;
  res_t               res;
  res_t               res_q;
  logic               pend_valid;
  command_t           pend_command;
  logic [DIGIT_W-1:0] pend_digit;
  logic               advance;
  logic               go;

  klk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !out_valid || !out_stall;
  assign go       = pend_valid && advance;
  assign in_stall = pend_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (!in_stall) begin
      pend_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pend_command <= command_t'(command);
      pend_digit   <= digit;
    end
  end

  klk_core u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .command (pend_command),
    .digit   (pend_digit),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) res_q <= res;
  end

  assign outcome         = res_q.outcome;
  assign entry_length    = res_q.entry_length;
  assign flow_state      = res_q.flow_state;
  assign new_digits_low  = res_q.new_digits[LOW_W-1:0];
  assign new_digits_high = res_q.new_digits[PW_W-1:LOW_W];
  assign new_length      = res_q.new_length;

endmodule

[verif/tb_keypad_password_lock_unit.sv]
module tb_keypad_password_lock_unit;
  import klk_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 12;
  localparam int KEYS_PER_PHASE = 160;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_SPACING   = 1200;

  typedef struct packed {
    outcome_t           oc;
    logic [COUNT_W-1:0] elen;
    phase_t             ph;
    logic [LOW_W-1:0]   nlo;
    logic [HIGH_W-1:0]  nhi;
    logic [COUNT_W-1:0] nlen;
  } lock_result_t;

  typedef struct packed {
    bit                 is_cfg;
    reg_index_t         reg_sel;
    logic [DATA_W-1:0]  value;
    command_t           cmd;
    logic [DIGIT_W-1:0] dig;
    bit                 typed;
    lock_result_t       want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = '0;
  logic [DIGIT_W-1:0] digit = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         outcome;
  logic [COUNT_W-1:0] entry_length;
  logic [1:0]         flow_state;
  logic [LOW_W-1:0]   new_digits_low;
  logic [HIGH_W-1:0]  new_digits_high;
  logic [COUNT_W-1:0] new_length;

  keypad_password_lock_unit dut (.*);

  always #1 clk = ~clk;

  // lock model state and register copies
  logic [DIGIT_W-1:0] entry_buf [0:MAX_DIGITS-1];
  logic [DIGIT_W-1:0] cand_buf [0:MAX_DIGITS-1];
  int                 entry_cnt = 0;
  int                 cand_cnt = 0;
  phase_t             lock_phase = PH_VERIFY;
  logic [LOW_W-1:0]   pw_lo_reg = '0;
  logic [HIGH_W-1:0]  pw_hi_reg = '0;
  logic [COUNT_W-1:0] pw_len_reg = '0;
  logic               mode_reg = 1'b0;

  lock_result_t       lock_replies_due [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 keys_accepted = 0;
  int                 hold_left = 0;
  int                 next_hold = 300;
  bit                 quiet = 1'b0;
  bit                 cur_typed = 1'b0;
  lock_result_t       cur_want = '0;
  plan_row_t          plan [$];
  logic [DIGIT_W-1:0] key_seq [0:23];
  int                 key_len = 0;
  logic [DIGIT_W-1:0] new_code [0:23];
  int                 new_code_len = 0;

  function automatic logic [DIGIT_W-1:0] pw_digit(int i);
    if (i < 16) return pw_lo_reg[4*i +: 4];
    return pw_hi_reg[4*(i-16) +: 4];
  endfunction

  function automatic bit entry_is_password();
    if (entry_cnt != int'(pw_len_reg)) return 1'b0;
    for (int i = 0; i < entry_cnt; i++)
      if (entry_buf[i] != pw_digit(i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit entry_is_candidate();
    if (entry_cnt != cand_cnt) return 1'b0;
    for (int i = 0; i < entry_cnt; i++)
      if (entry_buf[i] != cand_buf[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic advance_lock(input command_t c, input logic [DIGIT_W-1:0] d,
                              output lock_result_t r);
    r = '0;
    r.oc = OUT_NONE;
    case (c)
      CMD_DIGIT: begin
        if (d <= MAX_DIGIT_VALUE && entry_cnt < MAX_DIGITS) begin
          entry_buf[entry_cnt] = d;
          entry_cnt++;
        end
      end
      CMD_BACK: begin
        if (entry_cnt > 0) entry_cnt--;
      end
      CMD_START: begin
        entry_cnt = 0;
        lock_phase = mode_reg ? PH_OLD : PH_VERIFY;
      end
      default: begin
        case (lock_phase)
          PH_VERIFY, PH_OLD: begin
            if (!entry_is_password()) begin
              r.oc = OUT_ERROR;
            end else if (lock_phase == PH_VERIFY) begin
              r.oc = OUT_OPEN;
              entry_cnt = 0;
            end else begin
              r.oc = OUT_OLD_OK;
              entry_cnt = 0;
              lock_phase = PH_NEW;
            end
          end
          PH_NEW: begin
            for (int i = 0; i < entry_cnt; i++) cand_buf[i] = entry_buf[i];
            cand_cnt = entry_cnt;
            entry_cnt = 0;
            lock_phase = PH_CONFIRM;
            r.oc = OUT_NEW_TAKEN;
          end
          default: begin
            if (!entry_is_candidate()) begin
              r.oc = OUT_ERROR;
            end else begin
              r.oc = OUT_CHANGED;
              for (int i = 0; i < cand_cnt; i++) begin
                if (i < 16) r.nlo[4*i +: 4] = cand_buf[i];
                else r.nhi[4*(i-16) +: 4] = cand_buf[i];
              end
              r.nlen = COUNT_W'(cand_cnt);
              entry_cnt = 0;
              lock_phase = PH_VERIFY;
            end
          end
        endcase
      end
    endcase
    r.elen = COUNT_W'(entry_cnt);
    r.ph = lock_phase;
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  always @(posedge clk) begin
    lock_result_t got;
    lock_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        advance_lock(command_t'(command), digit, got);
        lock_replies_due.push_back(cur_typed ? cur_want : got);
        keys_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (lock_replies_due.size() == 0) begin
          note_mismatch("result with nothing pending", '0, 64'(outcome));
        end else begin
          want = lock_replies_due.pop_front();
          if (outcome !== want.oc)
            note_mismatch("outcome", 64'(want.oc), 64'(outcome));
          if (entry_length !== want.elen)
            note_mismatch("entry_length", 64'(want.elen), 64'(entry_length));
          if (flow_state !== want.ph)
            note_mismatch("flow_state", 64'(want.ph), 64'(flow_state));
          if (new_digits_low !== want.nlo)
            note_mismatch("new_digits_low", want.nlo, new_digits_low);
          if (new_digits_high !== want.nhi)
            note_mismatch("new_digits_high", 64'(want.nhi), 64'(new_digits_high));
          if (new_length !== want.nlen)
            note_mismatch("new_length", 64'(want.nlen), 64'(new_length));
        end
      end
    end
  end

  // receiver: random stalls plus a long hold so the block backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (keys_accepted >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += HOLD_SPACING;
    end
    out_stall <= hold_left > 0 || (!quiet && $urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_key(input command_t c, input logic [DIGIT_W-1:0] d, input bit typed,
                          input lock_result_t want);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    digit <= d;
    cur_typed <= typed;
    cur_want <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic press(input command_t c, input logic [DIGIT_W-1:0] d);
    send_key(c, d, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (lock_replies_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t r, input logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_PW_LOW:  pw_lo_reg = v;
      REG_PW_HIGH: pw_hi_reg = v[HIGH_W-1:0];
      REG_PW_LEN:  pw_len_reg = v[COUNT_W-1:0];
      default:     mode_reg = v[0];
    endcase
    @(negedge clk);
  endtask

  function automatic void plan_cfg(reg_index_t r, logic [DATA_W-1:0] v);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = r;
    row.value = v;
    plan.push_back(row);
  endfunction

  function automatic void plan_key(command_t c, logic [DIGIT_W-1:0] d);
    plan_row_t row;
    row = '0;
    row.cmd = c;
    row.dig = d;
    plan.push_back(row);
  endfunction

  function automatic void plan_check(command_t c, logic [DIGIT_W-1:0] d, outcome_t oc,
                                     int elen, phase_t ph);
    plan_row_t row;
    row = '0;
    row.cmd = c;
    row.dig = d;
    row.typed = 1'b1;
    row.want.oc = oc;
    row.want.elen = COUNT_W'(elen);
    row.want.ph = ph;
    plan.push_back(row);
  endfunction

  task automatic type_keys();
    for (int i = 0; i < key_len; i++) begin
      case ($urandom_range(19))
        0: press(CMD_DIGIT, 4'($urandom_range(15, 10)));
        1: begin
          press(CMD_DIGIT, 4'($urandom_range(9)));
          press(CMD_BACK, 4'($urandom));
        end
        default: ;
      endcase
      press(CMD_DIGIT, key_seq[i]);
    end
  endtask

  task automatic load_password();
    key_len = pw_len_reg > MAX_DIGITS ? MAX_DIGITS : int'(pw_len_reg);
    for (int i = 0; i < key_len; i++) key_seq[i] = pw_digit(i);
  endtask

  task automatic recall_code();
    key_len = new_code_len;
    for (int i = 0; i < key_len; i++) key_seq[i] = new_code[i];
  endtask

  task automatic spoil_keys();
    int j;
    case ($urandom_range(2))
      0: begin
        if (key_len > 0) begin
          j = $urandom_range(key_len - 1);
          key_seq[j] = key_seq[j] == 4'd9 ? 4'd0 : key_seq[j] + 4'd1;
        end
      end
      1: begin
        if (key_len > 0) key_len--;
      end
      default: begin
        if (key_len < MAX_DIGITS) begin
          key_seq[key_len] = 4'($urandom_range(9));
          key_len++;
        end
      end
    endcase
  endtask

  task automatic run_episode();
    int pick;
    bit spoiled;
    pick = $urandom_range(99);
    if (pick < 30) begin
      press(CMD_START, 4'($urandom));
      load_password();
      if ($urandom_range(2) == 0) spoil_keys();
      type_keys();
      press(CMD_ENTER, 4'($urandom));
    end else if (pick < 60) begin
      // full change flow: old, new, confirm
      press(CMD_START, 4'($urandom));
      load_password();
      if ($urandom_range(9) == 0) spoil_keys();
      type_keys();
      press(CMD_ENTER, 4'($urandom));
      case ($urandom_range(3))
        0:       key_len = MAX_DIGITS;
        1:       key_len = $urandom_range(MAX_DIGITS);
        default: key_len = $urandom_range(6, 1);
      endcase
      for (int i = 0; i < key_len; i++) key_seq[i] = 4'($urandom_range(9));
      for (int i = 0; i < key_len; i++) new_code[i] = key_seq[i];
      new_code_len = key_len;
      type_keys();
      press(CMD_ENTER, 4'($urandom));
      recall_code();
      spoiled = $urandom_range(4) == 0;
      if (spoiled) spoil_keys();
      type_keys();
      press(CMD_ENTER, 4'($urandom));
      if (spoiled) begin
        recall_code();
        type_keys();
        press(CMD_ENTER, 4'($urandom));
      end
    end else if (pick < 75) begin
      load_password();
      if ($urandom_range(1) == 0) spoil_keys();
      type_keys();
      press(CMD_ENTER, 4'($urandom));
    end else if (pick < 85) begin
      // overfill the entry buffer
      key_len = $urandom_range(23, 18);
      for (int i = 0; i < key_len; i++) key_seq[i] = 4'($urandom_range(9));
      type_keys();
      repeat ($urandom_range(3)) press(CMD_BACK, 4'($urandom));
      press(CMD_ENTER, 4'($urandom));
    end else begin
      repeat ($urandom_range(6, 1)) press(command_t'($urandom_range(3)), 4'($urandom));
    end
  endtask

  initial begin
    int phase_end;
    int len;
    logic [LOW_W-1:0] lo;
    logic [HIGH_W-1:0] hi;

    // reset registers: empty password, verify flow
    plan_check(CMD_ENTER, 4'd0,  OUT_OPEN,  0, PH_VERIFY);
    plan_check(CMD_BACK,  4'd0,  OUT_NONE,  0, PH_VERIFY);
    plan_check(CMD_DIGIT, 4'd15, OUT_NONE,  0, PH_VERIFY);
    plan_check(CMD_DIGIT, 4'd10, OUT_NONE,  0, PH_VERIFY);
    plan_check(CMD_DIGIT, 4'd0,  OUT_NONE,  1, PH_VERIFY);
    plan_check(CMD_ENTER, 4'd0,  OUT_ERROR, 1, PH_VERIFY);
    plan_key(CMD_DIGIT, 4'd9);
    plan_check(CMD_BACK,  4'd0,  OUT_NONE,  1, PH_VERIFY);
    // password 9 0 5, change flow
    plan_cfg(REG_PW_LOW, 64'h509);
    plan_cfg(REG_PW_HIGH, 64'hffff);
    plan_cfg(REG_PW_LEN, 64'd3);
    plan_cfg(REG_MODE, 64'd1);
    plan_check(CMD_ENTER, 4'd0,  OUT_ERROR, 1, PH_VERIFY);
    plan_check(CMD_START, 4'd0,  OUT_NONE,  0, PH_OLD);
    plan_key(CMD_DIGIT, 4'd9);
    plan_key(CMD_DIGIT, 4'd0);
    plan_key(CMD_DIGIT, 4'd5);
    plan_check(CMD_ENTER, 4'd0,  OUT_OLD_OK, 0, PH_NEW);
    plan_key(CMD_DIGIT, 4'd1);
    plan_key(CMD_DIGIT, 4'd2);
    plan_check(CMD_ENTER, 4'd0,  OUT_NEW_TAKEN, 0, PH_CONFIRM);
    plan_key(CMD_DIGIT, 4'd1);
    plan_check(CMD_ENTER, 4'd0,  OUT_ERROR, 1, PH_CONFIRM);
    plan_key(CMD_DIGIT, 4'd2);
    plan_key(CMD_ENTER, 4'd0);
    // stored length beyond the buffer never matches
    plan_cfg(REG_PW_LEN, 64'd31);
    plan_cfg(REG_MODE, 64'd0);
    plan_cfg(REG_PW_LOW, 64'hffff_ffff_ffff_ffff);
    plan_check(CMD_START, 4'd0,  OUT_NONE,  0, PH_VERIFY);
    plan_check(CMD_ENTER, 4'd0,  OUT_ERROR, 0, PH_VERIFY);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        settle();
        write_reg(plan[k].reg_sel, plan[k].value);
      end else begin
        send_key(plan[k].cmd, plan[k].dig, plan[k].typed, plan[k].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p % 6)
        0:       len = MAX_DIGITS;
        1:       len = 0;
        2:       len = $urandom_range(31, MAX_DIGITS + 1);
        default: len = $urandom_range(MAX_DIGITS, 1);
      endcase
      lo = {$urandom, $urandom};
      hi = HIGH_W'($urandom);
      if (p % 4 != 3) begin
        for (int i = 0; i < 16; i++) lo[4*i +: 4] = 4'($urandom_range(9));
        for (int i = 0; i < 4; i++) hi[4*i +: 4] = 4'($urandom_range(9));
      end
      write_reg(REG_PW_LOW, lo);
      write_reg(REG_PW_HIGH, DATA_W'(hi));
      write_reg(REG_PW_LEN, DATA_W'(len));
      write_reg(REG_MODE, DATA_W'(p % 3 != 0));
      quiet = p == 4;
      phase_end = keys_accepted + KEYS_PER_PHASE;
      while (keys_accepted < phase_end) run_episode();
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
